// ===== hdl/bmexp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmexp_pkg
// Shared types and constants for the bitmap to RGB565 expander.
// ----------------------------------------------------------------------------
package bmexp_pkg;

  localparam int DEF_MAX_WIDTH  = 512;
  localparam int DEF_MAX_HEIGHT = 512;

  localparam int BYTE_W  = 8;
  localparam int PIXEL_W = 16;
  localparam int SIZE_W  = 10;  // image_width / image_height register width
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [1:0] {
    MODE_MONO   = 2'd0,
    MODE_RGB332 = 2'd1,
    MODE_RGB565 = 2'd2,
    MODE_UNUSED = 2'd3
  } pixel_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PIXEL_MODE   = 3'd0,
    REG_IMAGE_WIDTH  = 3'd1,
    REG_IMAGE_HEIGHT = 3'd2,
    REG_FORE_COLOR   = 3'd3,
    REG_BACK_COLOR   = 3'd4
  } cfg_reg_t;

  // Position status for the pixel about to be sent.
  typedef struct packed {
    logic row_end;  // pixel is the last of its row
    logic img_end;  // pixel is the last of the image
  } pos_t;

endpackage

// ===== hdl/bmexp_byte_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmexp_byte_if
// Bitmap byte stream channel: valid/ready with one byte per beat.
// ----------------------------------------------------------------------------
interface bmexp_byte_if;
  logic                         valid;
  logic                         ready;
  logic [bmexp_pkg::BYTE_W-1:0] bitmap_byte;

  modport source (output valid, output bitmap_byte, input ready);
  modport sink   (input valid, input bitmap_byte, output ready);
endinterface

// ===== hdl/bmexp_pix_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmexp_pix_if
// RGB565 pixel channel: valid/ready with one pixel and its flags per beat.
// ----------------------------------------------------------------------------
interface bmexp_pix_if;
  logic                          valid;
  logic                          ready;
  logic [bmexp_pkg::PIXEL_W-1:0] pixel_color;
  logic                          byte_done;
  logic                          image_done;

  modport source (output valid, output pixel_color, output byte_done,
                  output image_done, input ready);
  modport sink   (input valid, input pixel_color, input byte_done,
                  input image_done, output ready);
endinterface

// ===== hdl/bmexp_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmexp_cfg_if
// Configuration write channel: register index and data per beat.
// ----------------------------------------------------------------------------
interface bmexp_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [bmexp_pkg::CFG_IDX_W-1:0]  index;
  logic [bmexp_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/bmexp_pos_ctr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmexp_pos_ctr
// Column/row tracker: clamps the size registers, folds counters that sit
// past a shrunken size, and advances one pixel per step.
// ----------------------------------------------------------------------------
module bmexp_pos_ctr #(
  parameter int MAX_WIDTH  = bmexp_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bmexp_pkg::DEF_MAX_HEIGHT
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [bmexp_pkg::SIZE_W-1:0] width_cfg,
  input  logic [bmexp_pkg::SIZE_W-1:0] height_cfg,
  input  logic                         step,
  input  logic                         fold,
  output bmexp_pkg::pos_t              pos
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int WCW = ($clog2(MAX_WIDTH + 1) > bmexp_pkg::SIZE_W) ?
                       $clog2(MAX_WIDTH + 1) : bmexp_pkg::SIZE_W;
  localparam int HCW = ($clog2(MAX_HEIGHT + 1) > bmexp_pkg::SIZE_W) ?
                       $clog2(MAX_HEIGHT + 1) : bmexp_pkg::SIZE_W;
  localparam logic [WCW-1:0] MAX_W_C = WCW'(MAX_WIDTH);
  localparam logic [HCW-1:0] MAX_H_C = HCW'(MAX_HEIGHT);

  logic [CW-1:0]  col_r, col_nxt_c;
  logic [RW-1:0]  row_r, row_nxt_c;
  logic [WCW-1:0] w_ext, w_eff, col_ext, col_n, col_inc, col_nxt;
  logic [HCW-1:0] h_ext, h_eff, row_ext, row_n, row_inc, row_wrap, row_c, row_c_inc;
  logic [HCW-1:0] row_nxt;
  logic           row_end;

  always_comb begin
    w_ext = WCW'(width_cfg);
    h_ext = HCW'(height_cfg);
    w_eff = (w_ext == '0) ? WCW'(1) : ((w_ext > MAX_W_C) ? MAX_W_C : w_ext);
    h_eff = (h_ext == '0) ? HCW'(1) : ((h_ext > MAX_H_C) ? MAX_H_C : h_ext);

    col_ext = WCW'(col_r);
    row_ext = HCW'(row_r);

    // fold stale counters after a size change; a no-op when in range
    row_n    = (row_ext >= h_eff) ? '0 : row_ext;
    row_inc  = row_n + HCW'(1);
    row_wrap = (row_inc >= h_eff) ? '0 : row_inc;
    if (col_ext >= w_eff) begin
      col_n = '0;
      row_c = row_wrap;
    end else begin
      col_n = col_ext;
      row_c = row_n;
    end

    col_inc   = col_n + WCW'(1);
    row_c_inc = row_c + HCW'(1);
    row_end   = (col_inc >= w_eff);
    pos.row_end = row_end;
    pos.img_end = row_end && (row_c_inc >= h_eff);

    if (row_end) begin
      col_nxt = '0;
      row_nxt = (row_c_inc >= h_eff) ? '0 : row_c_inc;
    end else begin
      col_nxt = col_inc;
      row_nxt = row_c;
    end
    col_nxt_c = col_nxt[CW-1:0];
    row_nxt_c = row_nxt[RW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (step) begin
      col_r <= col_nxt_c;
      row_r <= row_nxt_c;
    end else if (fold) begin
      // a byte that gives no pixel still settles the position
      col_r <= col_n[CW-1:0];
      row_r <= row_c[RW-1:0];
    end
  end

endmodule

// ===== hdl/bitmap_to_rgb565_expander_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_to_rgb565_expander_unit
// Expands a padded-row bitmap byte stream into RGB565 pixels in raster order.
// ----------------------------------------------------------------------------
// Pixels leave through a single output register, one per cycle in monochrome
// and RGB332 modes while the pixel sink takes a beat every cycle. A monochrome
// byte gives min(8, pixels left in its row) pixels, an RGB332 byte one pixel,
// and an RGB565 pixel takes two input beats (the low byte is only held). A byte
// waits in one input register; the next byte is taken in the same cycle its
// predecessor's last pixel moves to the output register. Mode 3 bytes are
// swallowed. The user must write configuration only while the block is idle;
// the block itself does not enforce this. The config channel is always ready.
module bitmap_to_rgb565_expander_unit #(
  parameter int MAX_WIDTH  = bmexp_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bmexp_pkg::DEF_MAX_HEIGHT
) (
  input  logic        clk,
  input  logic        rst_n,
  bmexp_byte_if.sink  in_chan,
  bmexp_pix_if.source out_chan,
  bmexp_cfg_if.sink   cfg_chan
);

  localparam int BW = bmexp_pkg::BYTE_W;
  localparam int PW = bmexp_pkg::PIXEL_W;
  localparam int SW = bmexp_pkg::SIZE_W;

  function automatic logic [PW-1:0] expand332(input logic [BW-1:0] c);
    logic [2:0] r, g;
    logic [1:0] b;
    r = c[7:5];
    g = c[4:2];
    b = c[1:0];
    expand332 = {r, r[2:1], g, g, b, b, b[1]};
  endfunction

  // configuration registers
  bmexp_pkg::pixel_mode_t mode_r;
  logic [SW-1:0]          width_r, height_r;
  logic [PW-1:0]          fore_r, back_r;

  // input register
  logic          pend_valid_r, pend_valid_nxt;
  logic [BW-1:0] pend_byte_r;
  logic [2:0]    bit_r, bit_nxt;

  // RGB565 pairing
  logic          low_valid_r, low_valid_nxt;
  logic [BW-1:0] low_byte_r, low_byte_nxt;

  // output register
  logic          out_valid_r, out_valid_nxt;
  logic [PW-1:0] pix_r, pix_nxt;
  logic          byte_done_r, byte_done_nxt;
  logic          img_done_r, img_done_nxt;

  logic            out_free, emit, consume, accept, last_of_byte, hold;
  logic [PW-1:0]   pix_c;
  bmexp_pkg::pos_t pos;

  bmexp_pos_ctr #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_pos (
    .clk        (clk),
    .rst_n      (rst_n),
    .width_cfg  (width_r),
    .height_cfg (height_r),
    .step       (emit),
    .fold       (hold),
    .pos        (pos)
  );

  assign out_free = !out_valid_r || out_chan.ready;
  assign accept   = in_chan.valid && in_chan.ready;
  assign in_chan.ready  = !pend_valid_r || consume;
  assign cfg_chan.ready = 1'b1;

  always_comb begin
    emit         = 1'b0;
    consume      = 1'b0;
    hold         = 1'b0;
    last_of_byte = 1'b1;
    pix_c        = '0;
    bit_nxt      = bit_r;
    low_valid_nxt = low_valid_r;
    low_byte_nxt  = low_byte_r;
    case (mode_r)
      bmexp_pkg::MODE_MONO: begin
        last_of_byte = (bit_r == 3'd7) || pos.row_end;  // row padding dropped
        pix_c        = pend_byte_r[3'd7 - bit_r] ? fore_r : back_r;
        emit         = pend_valid_r && out_free;
        consume      = emit && last_of_byte;
        if (emit) begin
          bit_nxt       = last_of_byte ? 3'd0 : bit_r + 3'd1;
          low_valid_nxt = 1'b0;
        end
      end
      bmexp_pkg::MODE_RGB332: begin
        pix_c   = expand332(pend_byte_r);
        emit    = pend_valid_r && out_free;
        consume = emit;
        if (emit) low_valid_nxt = 1'b0;
      end
      bmexp_pkg::MODE_RGB565: begin
        pix_c = {pend_byte_r, low_byte_r};
        if (!low_valid_r) begin
          consume = pend_valid_r;
          hold    = pend_valid_r;
          if (pend_valid_r) begin
            low_byte_nxt  = pend_byte_r;
            low_valid_nxt = 1'b1;
          end
        end else begin
          emit    = pend_valid_r && out_free;
          consume = emit;
          if (emit) low_valid_nxt = 1'b0;
        end
      end
      bmexp_pkg::MODE_UNUSED: begin
        consume = pend_valid_r;
      end
      default: begin
        consume = pend_valid_r;
      end
    endcase

    pend_valid_nxt = accept ? 1'b1 : (consume ? 1'b0 : pend_valid_r);

    if (emit) begin
      out_valid_nxt = 1'b1;
      pix_nxt       = pix_c;
      byte_done_nxt = last_of_byte;
      img_done_nxt  = pos.img_end;
    end else begin
      out_valid_nxt = out_chan.ready ? 1'b0 : out_valid_r;
      pix_nxt       = pix_r;
      byte_done_nxt = byte_done_r;
      img_done_nxt  = img_done_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= bmexp_pkg::MODE_MONO;
      width_r  <= SW'(1);
      height_r <= SW'(1);
      fore_r   <= '1;
      back_r   <= '0;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        bmexp_pkg::REG_PIXEL_MODE:   mode_r   <= bmexp_pkg::pixel_mode_t'(cfg_chan.data[1:0]);
        bmexp_pkg::REG_IMAGE_WIDTH:  width_r  <= cfg_chan.data[SW-1:0];
        bmexp_pkg::REG_IMAGE_HEIGHT: height_r <= cfg_chan.data[SW-1:0];
        bmexp_pkg::REG_FORE_COLOR:   fore_r   <= cfg_chan.data[PW-1:0];
        bmexp_pkg::REG_BACK_COLOR:   back_r   <= cfg_chan.data[PW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      bit_r        <= 3'd0;
      low_valid_r  <= 1'b0;
      low_byte_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      pend_valid_r <= pend_valid_nxt;
      bit_r        <= bit_nxt;
      low_valid_r  <= low_valid_nxt;
      low_byte_r   <= low_byte_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) pend_byte_r <= in_chan.bitmap_byte;
    pix_r       <= pix_nxt;
    byte_done_r <= byte_done_nxt;
    img_done_r  <= img_done_nxt;
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.pixel_color = pix_r;
  assign out_chan.byte_done   = byte_done_r;
  assign out_chan.image_done  = img_done_r;

endmodule

// ===== hdl/bmexp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmexp_checker
// Port-level checks for the bitmap to RGB565 expander, bound to the top.
// ----------------------------------------------------------------------------
module bmexp_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [bmexp_pkg::PIXEL_W-1:0] out_pixel_color,
  input logic                          out_byte_done,
  input logic                          out_image_done
);

  // a stalled beat is held
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("pixel beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_pixel_color) && $stable(out_byte_done)
                                && $stable(out_image_done))
    else $error("pixel beat changed while stalled");

  // the last pixel of the image ends its row and so its byte
  a_img_ends_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_image_done |-> out_byte_done)
    else $error("image_done without byte_done");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("pixel valid right after reset");

endmodule

bind bitmap_to_rgb565_expander_unit bmexp_checker u_bmexp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_pixel_color (out_chan.pixel_color),
  .out_byte_done   (out_chan.byte_done),
  .out_image_done  (out_chan.image_done)
);
